// ----- hw/rtl/cogu_pkg.sv -----
// Shared types and constants for the coupled order Gibbs update block.
// Holds the request and response words, the register map and the codes.
// Depends on nothing; every other file but cogu_ram imports it.
package cogu_pkg;

    localparam logic [30:0] TOP_VALUE = 31'h7FFF_FFFF;
    localparam int          ADDR_W    = 3;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_RESTART = 2'd1,
        REQ_PROPOSE = 2'd2,
        REQ_GAP     = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        MS_SPRED = 2'd0,
        MS_SSUCC = 2'd1,
        MS_RPRED = 2'd2,
        MS_RSUCC = 2'd3
    } mat_code_t;

    typedef enum logic {
        REG_VERTEX_COUNT = 1'b0,
        REG_GAP_LIMIT    = 1'b1
    } reg_code_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  vertex;
        logic [1:0]  matrix_select;
        logic [63:0] row_bits;
        logic [30:0] proposal_value;
    } cogu_req_t;

    typedef struct packed {
        logic        low_accepted;
        logic        high_accepted;
        logic        coalesced;
        logic [30:0] max_gap;
    } cogu_rsp_t;

    typedef struct packed {
        logic [6:0]  vertex_count;
        logic [30:0] gap_limit;
    } cogu_cfg_t;

    typedef struct packed {
        logic lower;
        logic strict_hit;
        logic relaxed_hit;
    } cogu_nb_t;

endpackage

// ----- hw/rtl/cogu_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module cogu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/cogu_regs.sv -----
// APB-style configuration registers: vertex count and gap limit.
// Depends on cogu_pkg.
module cogu_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cogu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output cogu_pkg::cogu_cfg_t        cfg
);
    import cogu_pkg::*;

    cogu_cfg_t cfg_reg;
    logic      wr;

    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vertex_count <= 7'd64;
            cfg_reg.gap_limit    <= TOP_VALUE;
        end
        else if (wr)
        begin
            if (paddr[2] == REG_VERTEX_COUNT)
            begin
                cfg_reg.vertex_count <= pwdata[6:0];
            end
            else
            begin
                cfg_reg.gap_limit <= pwdata[30:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_VERTEX_COUNT)
        begin
            prdata = {25'd0, cfg_reg.vertex_count};
        end
        else
        begin
            prdata = {1'b0, cfg_reg.gap_limit};
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/cogu_check.sv -----
// Order and gap check of one neighbor against a proposed value in one chain.
// Depends on cogu_pkg.
module cogu_check (
    input  cogu_pkg::cogu_nb_t nb,
    input  logic [30:0]        nb_value,
    input  logic [30:0]        prop,
    input  logic [30:0]        limit,
    output logic               fail
);
    import cogu_pkg::*;

    logic [31:0] diff;
    logic        strict_bad;
    logic        relaxed_bad;

    always_comb
    begin
        if (nb.lower)
        begin
            diff       = {1'b0, nb_value} - {1'b0, prop};
            strict_bad = prop < nb_value;
        end
        else
        begin
            diff       = {1'b0, prop} - {1'b0, nb_value};
            strict_bad = nb_value < prop;
        end
        relaxed_bad = !diff[31] && (diff[30:0] > limit);
        fail = (nb.strict_hit && strict_bad) || (nb.relaxed_hit && relaxed_bad);
    end

endmodule

// ----- hw/rtl/coupled_order_gibbs_update.sv -----
// Coupled order Gibbs update. Both chains share one RAM entry per vertex and the
// four neighbor bitmaps share a second RAM; each RAM reads one entry per cycle.
// A proposal reads the four bitmap rows of its vertex and then one chain entry per
// vertex in use; a gap query scans all vertices in use once per vertex in use.
// Depends on cogu_pkg, cogu_ram, cogu_regs, cogu_check.
module coupled_order_gibbs_update #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  cogu_pkg::cogu_req_t         req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output cogu_pkg::cogu_rsp_t         rsp_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cogu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cogu_pkg::*;

    localparam int         VW   = $clog2(MAX_VERTICES);
    localparam int         BD   = 4 << VW;
    localparam logic [6:0] MAXV = 7'(MAX_VERTICES);

    typedef enum logic [2:0] {
        S_IDLE, S_ROWS, S_SCAN, S_WRITE, S_GAP_ISSUE, S_GAP_CAP, S_EMIT
    } state_t;

    cogu_cfg_t cfg;

    state_t            state_reg, state_next;
    logic              gap_mode_reg, gap_mode_next;
    logic [VW-1:0]     v_reg, v_next;
    logic [30:0]       p_reg, p_next;
    logic [1:0]        k_reg, k_next;
    logic [63:0]       rows_reg [4];
    logic [63:0]       rows_next [4];
    logic [30:0]       lv_reg, lv_next, hv_reg, hv_next;
    logic              lo_lower_reg, lo_lower_next, hi_lower_reg, hi_lower_next;
    logic              lo_fail_reg, lo_fail_next, hi_fail_reg, hi_fail_next;
    logic [VW-1:0]     iss_cnt_reg, iss_cnt_next;
    logic              iss_done_reg, iss_done_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [VW-1:0]     rd_idx_reg, rd_idx_next;
    logic [VW+1:0]     bm_idx_reg, bm_idx_next;
    logic [VW-1:0]     gi_reg, gi_next;
    logic [30:0]       gl_reg, gl_next;
    logic [63:0]       grow_reg, grow_next;
    logic [30:0]       best_reg, best_next;
    logic              lo_ok_reg, lo_ok_next, hi_ok_reg, hi_ok_next;
    logic [MAX_VERTICES-1:0] chain_vld_reg, chain_vld_next;
    logic [MAX_VERTICES-1:0] diff_reg, diff_next;
    logic [BD-1:0]     bmp_vld_reg, bmp_vld_next;
    logic              rsp_valid_reg, rsp_valid_next;
    cogu_rsp_t         rsp_reg, rsp_next;

    logic              ch_we;
    logic [VW-1:0]     ch_waddr, ch_raddr;
    logic [61:0]       ch_wdata, ch_q;
    logic              bm_we;
    logic [VW+1:0]     bm_waddr, bm_raddr;
    logic [63:0]       bm_q;

    logic [6:0]        n_use;
    logic [MAX_VERTICES-1:0] use_mask;
    logic [30:0]       rd_low, rd_high;
    logic [63:0]       bm_row;
    cogu_nb_t          lo_nb, hi_nb;
    logic              lo_bad, hi_bad;
    logic [31:0]       gdiff;
    logic [30:0]       new_low, new_high;

    cogu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cogu_ram #(.WIDTH(62), .DEPTH(MAX_VERTICES)) u_chain_ram (
        .clk   (clk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .raddr (ch_raddr),
        .rdata (ch_q)
    );

    cogu_ram #(.WIDTH(64), .DEPTH(BD)) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (req_data.row_bits),
        .raddr (bm_raddr),
        .rdata (bm_q)
    );

    always_comb
    begin
        if (cfg.vertex_count == 7'd0)
        begin
            n_use = 7'd1;
        end
        else if (cfg.vertex_count > MAXV)
        begin
            n_use = MAXV;
        end
        else
        begin
            n_use = cfg.vertex_count;
        end
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            use_mask[j] = 7'(j) < n_use;
        end
    end

    assign rd_low  = chain_vld_reg[rd_idx_reg] ? ch_q[61:31] : 31'd0;
    assign rd_high = chain_vld_reg[rd_idx_reg] ? ch_q[30:0] : TOP_VALUE;
    assign bm_row  = bmp_vld_reg[bm_idx_reg] ? bm_q : 64'd0;

    always_comb
    begin
        lo_nb.lower       = lo_lower_reg;
        lo_nb.strict_hit  = lo_lower_reg ? rows_reg[MS_SPRED][rd_idx_reg]
                                         : rows_reg[MS_SSUCC][rd_idx_reg];
        lo_nb.relaxed_hit = lo_lower_reg ? rows_reg[MS_RPRED][rd_idx_reg]
                                         : rows_reg[MS_RSUCC][rd_idx_reg];
        hi_nb.lower       = hi_lower_reg;
        hi_nb.strict_hit  = hi_lower_reg ? rows_reg[MS_SPRED][rd_idx_reg]
                                         : rows_reg[MS_SSUCC][rd_idx_reg];
        hi_nb.relaxed_hit = hi_lower_reg ? rows_reg[MS_RPRED][rd_idx_reg]
                                         : rows_reg[MS_RSUCC][rd_idx_reg];
    end

    cogu_check u_check_low (
        .nb       (lo_nb),
        .nb_value (rd_low),
        .prop     (p_reg),
        .limit    (cfg.gap_limit),
        .fail     (lo_bad)
    );

    cogu_check u_check_high (
        .nb       (hi_nb),
        .nb_value (rd_high),
        .prop     (p_reg),
        .limit    (cfg.gap_limit),
        .fail     (hi_bad)
    );

    assign gdiff    = {1'b0, gl_reg} - {1'b0, rd_low};
    assign new_low  = lo_fail_reg ? lv_reg : p_reg;
    assign new_high = hi_fail_reg ? hv_reg : p_reg;

    always_comb
    begin
        state_next     = state_reg;
        gap_mode_next  = gap_mode_reg;
        v_next         = v_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        rows_next      = rows_reg;
        lv_next        = lv_reg;
        hv_next        = hv_reg;
        lo_lower_next  = lo_lower_reg;
        hi_lower_next  = hi_lower_reg;
        lo_fail_next   = lo_fail_reg;
        hi_fail_next   = hi_fail_reg;
        iss_cnt_next   = iss_cnt_reg;
        iss_done_next  = iss_done_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        bm_idx_next    = bm_idx_reg;
        gi_next        = gi_reg;
        gl_next        = gl_reg;
        grow_next      = grow_reg;
        best_next      = best_reg;
        lo_ok_next     = lo_ok_reg;
        hi_ok_next     = hi_ok_reg;
        chain_vld_next = chain_vld_reg;
        diff_next      = diff_reg;
        bmp_vld_next   = bmp_vld_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ch_we          = 1'b0;
        ch_waddr       = v_reg;
        ch_wdata       = {new_low, new_high};
        ch_raddr       = iss_cnt_reg;
        bm_we          = 1'b0;
        bm_waddr       = {req_data.matrix_select, req_data.vertex[VW-1:0]};
        bm_raddr       = {MS_RSUCC, gi_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    v_next        = req_data.vertex[VW-1:0];
                    p_next        = req_data.proposal_value;
                    gap_mode_next = req_data.req_type == REQ_GAP;
                    lo_ok_next    = 1'b0;
                    hi_ok_next    = 1'b0;
                    best_next     = 31'd0;
                    state_next    = S_EMIT;
                    case (req_data.req_type)
                        REQ_LOAD:
                        begin
                            if ({1'b0, req_data.vertex} < MAXV)
                            begin
                                bm_we                  = 1'b1;
                                bmp_vld_next[bm_waddr] = 1'b1;
                            end
                        end
                        REQ_RESTART:
                        begin
                            chain_vld_next = '0;
                            diff_next      = '1;
                        end
                        REQ_PROPOSE:
                        begin
                            if ({1'b0, req_data.vertex} < n_use)
                            begin
                                ch_raddr    = req_data.vertex[VW-1:0];
                                rd_idx_next = req_data.vertex[VW-1:0];
                                bm_raddr    = {MS_SPRED, req_data.vertex[VW-1:0]};
                                bm_idx_next = bm_raddr;
                                k_next      = 2'd0;
                                state_next  = S_ROWS;
                            end
                        end
                        default:
                        begin
                            gi_next    = '0;
                            state_next = S_GAP_ISSUE;
                        end
                    endcase
                end
            end
            S_ROWS:
            begin
                rows_next[k_reg] = bm_row;
                if (k_reg == 2'd0)
                begin
                    lv_next       = rd_low;
                    hv_next       = rd_high;
                    lo_lower_next = p_reg < rd_low;
                    hi_lower_next = p_reg < rd_high;
                end
                if (k_reg != 2'd3)
                begin
                    bm_raddr    = {k_reg + 2'd1, v_reg};
                    bm_idx_next = bm_raddr;
                    k_next      = k_reg + 2'd1;
                end
                else
                begin
                    iss_cnt_next  = '0;
                    iss_done_next = 1'b0;
                    lo_fail_next  = 1'b0;
                    hi_fail_next  = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!iss_done_reg)
                begin
                    ch_raddr    = iss_cnt_reg;
                    rd_vld_next = 1'b1;
                    rd_idx_next = iss_cnt_reg;
                    if (7'(iss_cnt_reg) == n_use - 7'd1)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        iss_cnt_next = iss_cnt_reg + 1'b1;
                    end
                end
                if (rd_vld_reg)
                begin
                    if (gap_mode_reg)
                    begin
                        if (grow_reg[rd_idx_reg] && !gdiff[31] && gdiff[30:0] > best_reg)
                        begin
                            best_next = gdiff[30:0];
                        end
                    end
                    else
                    begin
                        lo_fail_next = lo_fail_reg | lo_bad;
                        hi_fail_next = hi_fail_reg | hi_bad;
                    end
                    if (7'(rd_idx_reg) == n_use - 7'd1)
                    begin
                        if (!gap_mode_reg)
                        begin
                            state_next = S_WRITE;
                        end
                        else if (7'(gi_reg) == n_use - 7'd1)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            gi_next    = gi_reg + 1'b1;
                            state_next = S_GAP_ISSUE;
                        end
                    end
                end
            end
            S_WRITE:
            begin
                ch_we                 = 1'b1;
                chain_vld_next[v_reg] = 1'b1;
                diff_next[v_reg]      = new_low != new_high;
                lo_ok_next            = !lo_fail_reg;
                hi_ok_next            = !hi_fail_reg;
                state_next            = S_EMIT;
            end
            S_GAP_ISSUE:
            begin
                ch_raddr    = gi_reg;
                rd_idx_next = gi_reg;
                bm_raddr    = {MS_RSUCC, gi_reg};
                bm_idx_next = bm_raddr;
                state_next  = S_GAP_CAP;
            end
            S_GAP_CAP:
            begin
                gl_next       = rd_low;
                grow_next     = bm_row;
                iss_cnt_next  = '0;
                iss_done_next = 1'b0;
                state_next    = S_SCAN;
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.low_accepted  = lo_ok_reg;
                    rsp_next.high_accepted = hi_ok_reg;
                    rsp_next.coalesced     = !(|(diff_reg & use_mask));
                    rsp_next.max_gap       = best_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_vld_reg    <= 1'b0;
            chain_vld_reg <= '0;
            diff_reg      <= '1;
            bmp_vld_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            chain_vld_reg <= chain_vld_next;
            diff_reg      <= diff_next;
            bmp_vld_reg   <= bmp_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gap_mode_reg <= gap_mode_next;
        v_reg        <= v_next;
        p_reg        <= p_next;
        k_reg        <= k_next;
        rows_reg     <= rows_next;
        lv_reg       <= lv_next;
        hv_reg       <= hv_next;
        lo_lower_reg <= lo_lower_next;
        hi_lower_reg <= hi_lower_next;
        lo_fail_reg  <= lo_fail_next;
        hi_fail_reg  <= hi_fail_next;
        iss_cnt_reg  <= iss_cnt_next;
        iss_done_reg <= iss_done_next;
        rd_idx_reg   <= rd_idx_next;
        bm_idx_reg   <= bm_idx_next;
        gi_reg       <= gi_next;
        gl_reg       <= gl_next;
        grow_reg     <= grow_next;
        best_reg     <= best_next;
        lo_ok_reg    <= lo_ok_next;
        hi_ok_reg    <= hi_ok_next;
        rsp_reg      <= rsp_next;
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for coupled_order_gibbs_update: random and directed words,
// an in-bench predictor of both chains and the gap scan, and APB register phases.
// Depends on cogu_pkg and the RTL of the block.
module tb_top;
    import cogu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    cogu_req_t   req_data;
    logic        rsp_valid;
    logic        rsp_ready;
    cogu_rsp_t   rsp_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    coupled_order_gibbs_update uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cogu_req_t   pending_words[$];
    cogu_rsp_t   expected_rsp[$];

    logic [63:0] nb_rows[4][64];
    logic [30:0] low_vals[64];
    logic [30:0] high_vals[64];
    logic [6:0]  cur_vertex_count;
    logic [30:0] cur_gap_limit;

    int          errors;
    int          results_seen;
    int          send_gap;
    int          ready_gap;
    int          stall_left;
    bit          long_stall_done;
    int          idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int active_count();
        if (cur_vertex_count == 0)
            return 1;
        if (cur_vertex_count > 64)
            return 64;
        return cur_vertex_count;
    endfunction

    function automatic logic [63:0] active_mask(int n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic bit try_move(ref logic [30:0] chain[64], input int v,
                                    input logic [30:0] p, input logic [63:0] mask);
        logic [63:0] strict_row;
        logic [63:0] relaxed_row;
        longint      nb;
        longint      pv;
        bit          lowering;
        lowering = p < chain[v];
        pv = p;
        strict_row = (lowering ? nb_rows[MS_SPRED][v] : nb_rows[MS_SSUCC][v]) & mask;
        relaxed_row = (lowering ? nb_rows[MS_RPRED][v] : nb_rows[MS_RSUCC][v]) & mask;
        for (int x = 0; x < 64; x++)
        begin
            nb = chain[x];
            if (strict_row[x] && (lowering ? (pv < nb) : (nb < pv)))
                return 1'b0;
            if (relaxed_row[x] && ((lowering ? (nb - pv) : (pv - nb)) > longint'(cur_gap_limit)))
                return 1'b0;
        end
        chain[v] = p;
        return 1'b1;
    endfunction

    function automatic cogu_rsp_t predict_update(cogu_req_t w);
        cogu_rsp_t   r;
        int          n;
        logic [63:0] mask;
        longint      best;
        longint      d;
        n = active_count();
        mask = active_mask(n);
        r = '0;
        r.coalesced = 1'b1;
        case (req_code_t'(w.req_type))
            REQ_LOAD:
                nb_rows[w.matrix_select][w.vertex] = w.row_bits;
            REQ_RESTART:
                for (int i = 0; i < 64; i++)
                begin
                    low_vals[i] = '0;
                    high_vals[i] = TOP_VALUE;
                end
            REQ_PROPOSE:
                if (w.vertex < n)
                begin
                    r.low_accepted = try_move(low_vals, w.vertex, w.proposal_value, mask);
                    r.high_accepted = try_move(high_vals, w.vertex, w.proposal_value, mask);
                end
            default:
            begin
                best = 0;
                for (int i = 0; i < n; i++)
                    for (int x = 0; x < n; x++)
                        if (nb_rows[MS_RSUCC][i][x])
                        begin
                            d = longint'(low_vals[i]) - longint'(low_vals[x]);
                            if (d > best)
                                best = d;
                        end
                r.max_gap = best[30:0];
            end
        endcase
        for (int i = 0; i < n; i++)
            if (low_vals[i] != high_vals[i])
                r.coalesced = 1'b0;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_rsp.push_back(predict_update(req_data));
            if (!req_valid || req_ready)
            begin
                if (send_gap > 0)
                begin
                    req_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_words.size() > 0)
                begin
                    req_valid <= 1'b1;
                    req_data <= pending_words.pop_front();
                    send_gap <= pick_gap();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            ready_gap <= 0;
            stall_left <= 0;
            long_stall_done <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_rsp.size() == 0)
                begin
                    $error("Unexpected response word %h", rsp_data);
                    errors++;
                end
                else
                begin
                    cogu_rsp_t e;
                    e = expected_rsp.pop_front();
                    if (rsp_data.low_accepted !== e.low_accepted)
                    begin
                        $error("low_accepted exp %0d got %0d", e.low_accepted,
                               rsp_data.low_accepted);
                        errors++;
                    end
                    if (rsp_data.high_accepted !== e.high_accepted)
                    begin
                        $error("high_accepted exp %0d got %0d", e.high_accepted,
                               rsp_data.high_accepted);
                        errors++;
                    end
                    if (rsp_data.coalesced !== e.coalesced)
                    begin
                        $error("coalesced exp %0d got %0d", e.coalesced, rsp_data.coalesced);
                        errors++;
                    end
                    if (rsp_data.max_gap !== e.max_gap)
                    begin
                        $error("max_gap exp %0d got %0d", e.max_gap, rsp_data.max_gap);
                        errors++;
                    end
                end
            end
            if (!long_stall_done && results_seen == 120)
            begin
                long_stall_done <= 1'b1;
                stall_left <= 400;
                rsp_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap <= ready_gap - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
                ready_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic add_word(req_code_t kind, int v, mat_code_t sel, logic [63:0] row,
                            logic [30:0] value);
        cogu_req_t w;
        w.req_type = kind;
        w.vertex = v[5:0];
        w.matrix_select = sel;
        w.row_bits = row;
        w.proposal_value = value;
        pending_words.push_back(w);
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_code_t idx, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_VERTEX_COUNT)
            cur_vertex_count = value[6:0];
        else
            cur_gap_limit = value[30:0];
    endtask

    function automatic logic [63:0] rand_row();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [30:0] rand_value(int v);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return 31'($urandom_range(0, 12));
        if (roll == 4)
            return 31'd0;
        if (roll == 5)
            return TOP_VALUE;
        if (roll == 6)
            return 31'(TOP_VALUE - $urandom_range(0, 12));
        if (roll == 7)
            return 31'(low_vals[v] + $urandom_range(0, 3));
        return 31'($urandom);
    endfunction

    task automatic random_phase(int count);
        int          n;
        int          v;
        int          roll;
        logic [63:0] mask;
        n = active_count();
        mask = active_mask(n);
        add_word(REQ_RESTART, $urandom_range(0, 63), mat_code_t'($urandom_range(0, 3)),
                 rand_row(), 31'($urandom));
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
            if (roll < 20)
                add_word(REQ_LOAD, v, mat_code_t'($urandom_range(0, 3)),
                         ($urandom_range(0, 3) == 0) ? rand_row()
                             : (rand_row() & rand_row() & mask), 31'($urandom));
            else if (roll < 24)
                add_word(REQ_RESTART, v, mat_code_t'($urandom_range(0, 3)), rand_row(),
                         31'($urandom));
            else if (roll < ((n > 16) ? 28 : 36))
                add_word(REQ_GAP, v, mat_code_t'($urandom_range(0, 3)), rand_row(),
                         31'($urandom));
            else
                add_word(REQ_PROPOSE, v, mat_code_t'($urandom_range(0, 3)), rand_row(),
                         rand_value(v));
        end
    endtask

    initial
    begin
        int phase_vc[8];
        int phase_gl[8];
        phase_vc = '{64, 1, 0, 127, 4, 8, 16, 2};
        phase_gl = '{32'h7FFF_FFFF, 0, 5, 1000, 3, 32'h7FFF_FFFF, 50, 0};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int m = 0; m < 4; m++)
            for (int i = 0; i < 64; i++)
                nb_rows[m][i] = '0;
        for (int i = 0; i < 64; i++)
        begin
            low_vals[i] = '0;
            high_vals[i] = TOP_VALUE;
        end
        cur_vertex_count = 7'd64;
        cur_gap_limit = TOP_VALUE;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_word(REQ_GAP, 0, MS_SPRED, '0, '0);
        add_word(REQ_PROPOSE, 63, MS_SPRED, '0, TOP_VALUE);
        add_word(REQ_PROPOSE, 63, MS_SPRED, '0, 31'd0);
        add_word(REQ_LOAD, 0, MS_SSUCC, '1, '0);
        add_word(REQ_PROPOSE, 0, MS_RSUCC, '0, 31'd5);
        add_word(REQ_LOAD, 1, MS_SPRED, 64'h1, '0);
        add_word(REQ_PROPOSE, 1, MS_SPRED, '0, 31'd3);
        add_word(REQ_LOAD, 2, MS_RPRED, 64'h4, '0);
        add_word(REQ_PROPOSE, 2, MS_RPRED, '0, 31'd7);
        add_word(REQ_LOAD, 62, MS_RSUCC, 64'hC000_0000_0000_0001, '0);
        add_word(REQ_PROPOSE, 62, MS_SPRED, '0, TOP_VALUE);
        add_word(REQ_GAP, 63, MS_RSUCC, '1, TOP_VALUE);
        add_word(REQ_RESTART, 63, MS_RSUCC, '1, TOP_VALUE);
        add_word(REQ_LOAD, 63, MS_RSUCC, '1, TOP_VALUE);
        add_word(REQ_GAP, 0, MS_SPRED, '0, '0);
        wait_idle();

        write_reg(REG_VERTEX_COUNT, 32'd4);
        write_reg(REG_GAP_LIMIT, 32'd0);
        add_word(REQ_PROPOSE, 5, MS_SPRED, '0, 31'd1);
        add_word(REQ_PROPOSE, 63, MS_SPRED, '0, 31'd1);
        add_word(REQ_LOAD, 3, MS_RPRED, 64'h8, '0);
        add_word(REQ_PROPOSE, 3, MS_SPRED, '0, 31'd9);
        add_word(REQ_PROPOSE, 3, MS_SPRED, '0, 31'd0);
        for (int i = 0; i < 4; i++)
            add_word(REQ_PROPOSE, i, MS_SPRED, '0, 31'd2);
        add_word(REQ_GAP, 0, MS_SPRED, '0, '0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_VERTEX_COUNT, phase_vc[ph]);
            write_reg(REG_GAP_LIMIT, phase_gl[ph]);
            random_phase(55);
            wait_idle();
        end

        repeat (50) @(posedge clk);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
